[sv/fccr_pkg.sv]
// shared types, constants and helper functions for the frequency-count replacement block
package fccr_pkg;

   localparam int NUM_ENTRIES = 16;
   localparam int TAG_BITS    = 20;
   localparam int BLOCK_BITS  = 20;
   localparam int CNT_BITS    = 32;
   localparam int IDX_BITS    = $clog2(NUM_ENTRIES);
   localparam int FILL_BITS   = $clog2(NUM_ENTRIES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_DATA_BITS = ((BLOCK_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_BITS  = 2 + BLOCK_BITS + 3 * CNT_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;

   typedef logic [TAG_BITS-1:0]   tag_type;
   typedef logic [BLOCK_BITS-1:0] block_type;
   typedef logic [CNT_BITS-1:0]   cnt_type;
   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [FILL_BITS-1:0]  fill_type;

   typedef struct packed {
      tag_type tag;
      cnt_type use_cnt;
      cnt_type age_cnt;
   } entry_type;

   typedef struct packed {
      logic    valid;
      tag_type tag;
   } item_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_APPEND,
      ST_LOAD,
      ST_BUBBLE,
      ST_EVICT,
      ST_RESP
   } state_type;

   function automatic cnt_type sat_inc(input cnt_type v);
      return (v == '1) ? v : v + CNT_BITS'(1);
   endfunction

   function automatic tag_type to_tag(input block_type b);
      logic [TAG_BITS+BLOCK_BITS-1:0] ext;
      ext = {{TAG_BITS{1'b0}}, b};
      return ext[TAG_BITS-1:0];
   endfunction

   function automatic block_type to_block(input tag_type t);
      logic [TAG_BITS+BLOCK_BITS-1:0] ext;
      ext = {{BLOCK_BITS{1'b0}}, t};
      return ext[BLOCK_BITS-1:0];
   endfunction

endpackage

[sv/fccr_front.sv]
// front end: accepts block references and queues their tags for the table engine
module fccr_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fccr_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // block_ref
   output fccr_pkg::item_type                   item,
   input  logic                                 item_pop
);
   import fccr_pkg::*;

   tag_type                q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   push;
   logic                   pop;

   assign req_tready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign pop        = item_pop && (count_ff != '0);
   assign item.valid = (count_ff != '0);
   assign item.tag   = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= to_tag(req_tdata[BLOCK_BITS-1:0]);
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> (count_ff != '0))
      else $error("pop from empty queue");
   a_push_held: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_BITS'(1)))
      else $error("push lost");

endmodule

[sv/fccr_engine.sv]
// back end: table search, append, bubble pass, eviction and result register
module fccr_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fccr_pkg::item_type                   item,
   output logic                                 item_pop,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fccr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import fccr_pkg::*;

   entry_type  mem_ff [NUM_ENTRIES];
   entry_type  rd_data_ff;
   logic       mem_we;
   idx_type    mem_waddr;
   idx_type    mem_raddr;
   entry_type  mem_wdata;

   state_type  state_ff, state_in;
   idx_type    idx_ff, idx_in;
   fill_type   fill_ff, fill_in;
   tag_type    tag_ff, tag_in;
   entry_type  carry_ff, carry_in;
   logic       hit_ff, hit_in;
   logic       evv_ff, evv_in;
   block_type  evb_ff, evb_in;
   cnt_type    fault_ff, fault_in;
   cnt_type    hits_ff, hits_in;
   cnt_type    refs_ff, refs_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   entry_type  ent;
   logic       swap;
   logic       load_out;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      tag_in       = tag_ff;
      carry_in     = carry_ff;
      hit_in       = hit_ff;
      evv_in       = evv_ff;
      evb_in       = evb_ff;
      fault_in     = fault_ff;
      hits_in      = hits_ff;
      refs_in      = refs_ff;
      item_pop     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = idx_ff;
      mem_raddr    = '0;
      mem_wdata    = rd_data_ff;
      ent          = rd_data_ff;
      swap         = 1'b0;
      load_out     = 1'b0;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (item.valid) begin
               item_pop = 1'b1;
               tag_in   = item.tag;
               refs_in  = sat_inc(refs_ff);
               hit_in   = 1'b0;
               evv_in   = 1'b0;
               evb_in   = '0;
               idx_in   = '0;
               if (fill_ff == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            ent.age_cnt = sat_inc(rd_data_ff.age_cnt);
            mem_we      = 1'b1;
            if (rd_data_ff.tag == tag_ff) begin
               ent.use_cnt = sat_inc(rd_data_ff.use_cnt);
               hits_in     = sat_inc(hits_ff);
               hit_in      = 1'b1;
               state_in    = ST_RESP;
            end else if (idx_ff == IDX_BITS'(fill_ff - FILL_BITS'(1))) begin
               if (fill_ff == FILL_BITS'(NUM_ENTRIES)) begin
                  fault_in = sat_inc(fault_ff);
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_APPEND;
               end
            end else begin
               mem_raddr = idx_ff + IDX_BITS'(1);
               idx_in    = idx_ff + IDX_BITS'(1);
            end
            mem_wdata = ent;
         end
         ST_APPEND: begin
            mem_we    = 1'b1;
            mem_waddr = fill_ff[IDX_BITS-1:0];
            mem_wdata = '{tag: tag_ff, use_cnt: '0, age_cnt: '0};
            fill_in   = fill_ff + FILL_BITS'(1);
            state_in  = ST_RESP;
         end
         ST_LOAD: begin
            carry_in  = rd_data_ff;
            mem_raddr = IDX_BITS'(1);
            idx_in    = '0;
            state_in  = ST_BUBBLE;
         end
         ST_BUBBLE: begin
            swap = (carry_ff.use_cnt < rd_data_ff.use_cnt) ||
                   ((carry_ff.use_cnt == rd_data_ff.use_cnt) &&
                    (carry_ff.age_cnt > rd_data_ff.age_cnt));
            mem_we    = 1'b1;
            mem_wdata = swap ? rd_data_ff : carry_ff;
            carry_in  = swap ? carry_ff : rd_data_ff;
            if (idx_ff == IDX_BITS'(NUM_ENTRIES - 2)) begin
               state_in = ST_EVICT;
            end else begin
               mem_raddr = idx_ff + IDX_BITS'(2);
               idx_in    = idx_ff + IDX_BITS'(1);
            end
         end
         ST_EVICT: begin
            evv_in    = 1'b1;
            evb_in    = to_block(carry_ff.tag);
            mem_we    = 1'b1;
            mem_waddr = IDX_BITS'(NUM_ENTRIES - 1);
            mem_wdata = '{tag: tag_ff, use_cnt: '0, age_cnt: '0};
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_out    = 1'b1;
               rsp_data_in = RSP_DATA_BITS'({refs_ff, hits_ff, fault_ff, evb_ff, evv_ff, hit_ff});
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load_out || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         fault_ff     <= '0;
         hits_ff      <= '0;
         refs_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         fault_ff     <= fault_in;
         hits_ff      <= hits_in;
         refs_ff      <= refs_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff      <= idx_in;
      tag_ff      <= tag_in;
      carry_ff    <= carry_in;
      hit_ff      <= hit_in;
      evv_ff      <= evv_in;
      evb_ff      <= evb_in;
      rsp_data_ff <= rsp_data_in;
   end

   // entry table, one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_ff[mem_raddr];
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(NUM_ENTRIES))
      else $error("fill level beyond table depth");
   a_hits_le_refs: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= refs_ff)
      else $error("hit total exceeds reference total");
   a_faults_le_refs: assert property (@(posedge clock) disable iff (reset)
      fault_ff <= refs_ff)
      else $error("fault total exceeds reference total");
   a_bubble_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUBBLE) |-> (fill_ff == FILL_BITS'(NUM_ENTRIES)))
      else $error("bubble pass on a table that is not full");
   a_resp_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RESP && state_in == ST_IDLE) |=> rsp_valid_ff)
      else $error("finished result not presented");

endmodule

[sv/frequency_count_cache_replacement_top.sv]
// top level of the frequency-count cache replacement block with age tie-break
// Each accepted block reference yields one result. A hit updates its entry and goes to
// the result register, a miss on a table that is not full appends the tag, and a miss on
// a full table loads the first entry, makes a bubble pass and evicts: the engine walks
// the table through an entry memory with one write port and one registered read port, one
// entry per cycle for the search and again for the bubble pass. A two-deep input queue
// takes new references while the engine works and the output register holds a result.
module frequency_count_cache_replacement_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fccr_pkg::REQ_DATA_BITS-1:0]   req_tdata,  // block_ref
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // hit, evicted_valid, evicted_block, fault_total, hit_total, ref_total
   output logic [fccr_pkg::RSP_DATA_BITS-1:0]   rsp_tdata
);
   import fccr_pkg::*;

   item_type item;
   logic     item_pop;

   fccr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .item       (item),
      .item_pop   (item_pop)
   );

   fccr_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .item       (item),
      .item_pop   (item_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
